/* rtl/assert_macros.svh */
// Assertion helper macro for the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond) \
        else $error("assertion failed");
`endif

/* rtl/gfrd_pkg.sv */
// Package for the grid frequency response dispatch core.
// Types, constants and state codes; no dependencies.
`default_nettype none
package gfrd_pkg;
    localparam int MaxTurbines = 32;
    localparam logic signed [20:0] Nominal = 21'sd500000;

    typedef struct packed {
        logic        command;
        logic [19:0] frequency;
        logic [4:0]  turbine_index;
        logic        turbine_running;
        logic [15:0] turbine_power_kw;
        logic [15:0] turbine_min_kw;
        logic [15:0] turbine_max_kw;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  unit_index;
        logic [15:0] setpoint_kw;
        logic [1:0]  fr_mode;
        logic [20:0] total_power_kw;
        logic        last;
    } out_word_t;

    typedef enum logic [1:0] {
        MODE_READY    = 2'd0,
        MODE_ACTIVE   = 2'd1,
        MODE_RECOVERY = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PI,
        ST_MAG,
        ST_RESP,
        ST_COUNT,
        ST_DIV,
        ST_WALK
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic tick;
        logic pi;
        logic mag;
        logic resp;
        logic count_clr;
        logic count_step;
        logic div_start;
        logic walk_step;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic idx_end;
    } status_t;

    localparam logic [1:0] RegRated = 2'd0;
    localparam logic [1:0] RegCount = 2'd1;
endpackage
`default_nettype wire

/* rtl/grid_frequency_response_dispatch_core.sv */
// Grid frequency response dispatch core.
// Channels: start/busy command input (word accepted when start & !busy),
// result output marked by strobe for one cycle; APB config port.
// A load word is taken while idle and gives no result. A tick word runs an
// integral step, the response steps (magnitude, then scale and clamp),
// a count pass over the walked records, a bit-serial divide of the
// response by the running count, then a walk step for each record; each
// result word is registered and appears in the cycle after its walk step.
// A new word is taken only once the tick is done and busy is low; with no
// running walked record the divide is cut short. The count pass, the
// bit-serial divider and the single table read port set the busy time.
// Results cannot be held off by the receiver.
// Reset clears mode, integral, running flags and registers to defaults;
// stored power reads as zero for a record until it is loaded.
// Register 0 (addr 0): rated_total_kw; register 1 (addr 4): turbine_count.
`default_nettype none
`include "assert_macros.svh"
module grid_frequency_response_dispatch_core #(
    parameter int MAX_TURBINES = gfrd_pkg::MaxTurbines
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire gfrd_pkg::in_word_t in_word,
    output logic                    busy,
    output gfrd_pkg::out_word_t     result,
    output logic                    strobe,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [21:0] rated_reg;
    logic [5:0]  count_reg;
    gfrd_pkg::cmd_t cmd;
    gfrd_pkg::status_t status;
    logic [1:0] mode;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rated_reg <= 22'd100000;
            count_reg <= 6'd1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == gfrd_pkg::RegRated[0] && paddr[1:0] == 2'd0)
                rated_reg <= pwdata[21:0];
            else if (paddr[2] == gfrd_pkg::RegCount[0] && paddr[1:0] == 2'd0)
                count_reg <= pwdata[5:0];
        end
    end
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == gfrd_pkg::RegRated[0]) prdata = 32'(rated_reg);
            else prdata = 32'(count_reg);
        end
    end

    gfrd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .command(in_word.command),
        .status(status), .cmd(cmd), .busy(busy)
    );

    gfrd_datapath #(.MAX_TURBINES(MAX_TURBINES)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .cmd(cmd),
        .rated_total_kw(rated_reg), .turbine_count(count_reg),
        .status(status), .result(result), .strobe(strobe), .mode(mode)
    );

    `ASSERT_IMPL(a_strobe_busy, clk, rst_n, strobe |-> $past(busy))
    `ASSERT_IMPL(a_mode_legal, clk, rst_n, mode != 2'd3)
    `ASSERT_IMPL(a_load_no_result, clk, rst_n, (start && !busy && !in_word.command) |=> !strobe)
endmodule
`default_nettype wire

/* rtl/gfrd_ctrl.sv */
// Controller state machine of the dispatch core.
// Uses gfrd_pkg; drives gfrd_datapath through cmd_t / status_t.
`default_nettype none
module gfrd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              command,
    input  wire gfrd_pkg::status_t status,
    output gfrd_pkg::cmd_t         cmd,
    output logic                   busy
);
    gfrd_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gfrd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            gfrd_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (command)
                    begin
                        cmd.tick = 1'b1;
                        state_next = gfrd_pkg::ST_PI;
                    end
                    else
                        cmd.load = 1'b1;
                end
            end
            gfrd_pkg::ST_PI:
            begin
                cmd.pi = 1'b1;
                cmd.count_clr = 1'b1;
                state_next = gfrd_pkg::ST_MAG;
            end
            gfrd_pkg::ST_MAG:
            begin
                cmd.mag = 1'b1;
                state_next = gfrd_pkg::ST_RESP;
            end
            gfrd_pkg::ST_RESP:
            begin
                cmd.resp = 1'b1;
                state_next = gfrd_pkg::ST_COUNT;
            end
            gfrd_pkg::ST_COUNT:
            begin
                cmd.count_step = 1'b1;
                if (status.idx_end)
                begin
                    cmd.div_start = 1'b1;
                    state_next = gfrd_pkg::ST_DIV;
                end
            end
            gfrd_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = gfrd_pkg::ST_WALK;
            end
            gfrd_pkg::ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.idx_end)
                    state_next = gfrd_pkg::ST_IDLE;
            end
            default:
                state_next = gfrd_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/gfrd_datapath.sv */
// Datapath of the dispatch core: turbine table, mode/PI logic, divider, walk.
// Uses gfrd_pkg; sequenced by gfrd_ctrl.
`default_nettype none
module gfrd_datapath #(
    parameter int MAX_TURBINES = gfrd_pkg::MaxTurbines
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gfrd_pkg::in_word_t in_word,
    input  wire gfrd_pkg::cmd_t     cmd,
    input  wire logic [21:0]        rated_total_kw,
    input  wire logic [5:0]         turbine_count,
    output gfrd_pkg::status_t       status,
    output gfrd_pkg::out_word_t     result,
    output logic                    strobe,
    output logic [1:0]              mode
);
    localparam int WalkMax = (MAX_TURBINES < 32) ? MAX_TURBINES : 32;
    localparam int IdxW = (WalkMax > 1) ? $clog2(WalkMax) : 1;
    // ceil(2^22 / 5) and ceil(2^32 / 125) for reciprocal scaling
    localparam logic [19:0] Recip5 = 20'd838861;
    localparam logic [25:0] Recip125 = 26'd34359739;

    logic [WalkMax-1:0] running_reg;
    logic [WalkMax-1:0] loaded_reg;
    logic [15:0] power_mem [WalkMax];
    logic [15:0] min_mem [WalkMax];
    logic [15:0] max_mem [WalkMax];
    logic [15:0] pow_q, min_q, max_q;
    logic [15:0] pow_rd, min_rd, max_rd;

    gfrd_pkg::mode_t mode_reg;
    logic signed [39:0] integ_reg;
    logic signed [20:0] dev_reg;
    logic signed [19:0] resp_reg;
    logic [5:0] walk_reg;
    logic [5:0] idx_reg;
    logic [5:0] nrun_reg;
    logic signed [18:0] per_reg;
    logic [20:0] total_reg;

    // divider state: |resp| / n, restoring, one bit per cycle
    logic [18:0] quo_reg;
    logic [18:0] rem_reg;
    logic [4:0]  dcnt_reg;
    logic        dbusy_reg;
    logic        dneg_reg;

    gfrd_pkg::out_word_t result_reg;
    logic strobe_reg;

    // ---- tick: deviation and mode ----
    logic signed [20:0] dev_in;
    logic [20:0] ad_in;
    gfrd_pkg::mode_t mode_next;
    logic clr_integ;
    assign dev_in = $signed({1'b0, in_word.frequency}) - gfrd_pkg::Nominal;
    assign ad_in = dev_in[20] ? 21'(-dev_in) : dev_in;

    always_comb
    begin
        mode_next = mode_reg;
        clr_integ = 1'b0;
        case (mode_reg)
            gfrd_pkg::MODE_READY:
                if (ad_in > 21'd1000) mode_next = gfrd_pkg::MODE_ACTIVE;
            gfrd_pkg::MODE_ACTIVE:
                if (ad_in < 21'd200) mode_next = gfrd_pkg::MODE_RECOVERY;
            gfrd_pkg::MODE_RECOVERY:
                if (ad_in < 21'd30)
                begin
                    mode_next = gfrd_pkg::MODE_READY;
                    clr_integ = 1'b1;
                end
            default:
                mode_next = gfrd_pkg::MODE_READY;
        endcase
    end

    // ---- PI stage (cycle after tick) ----
    logic [20:0] ad_reg;
    logic signed [41:0] sum_w;
    logic signed [39:0] integ_new;
    localparam logic signed [41:0] ILim = 42'sd549755813887;
    assign sum_w = 42'(integ_reg) + 42'(dev_reg);
    always_comb
    begin
        integ_new = integ_reg;
        if (ad_reg > 21'd50)
        begin
            if (sum_w > ILim) integ_new = 40'(ILim);
            else if (sum_w < -ILim) integ_new = 40'(-ILim);
            else integ_new = 40'(sum_w);
        end
    end

    // ---- response: magnitude cycle, then scale and clamp cycle ----
    logic signed [30:0] d375_w;
    logic signed [42:0] num_w;
    logic [41:0] mag_w;
    logic [39:0] lim_prod_w;
    logic [41:0] mag_reg;
    logic        neg_reg;
    logic [17:0] lim_reg;
    logic [50:0] q_prod_w;
    logic [18:0] q_w;
    logic [18:0] qc_w;
    logic signed [19:0] resp_w;
    assign d375_w = 31'(dev_reg) * 31'sd375;
    assign num_w = -(43'(d375_w) + 43'($signed({integ_reg, 1'b0})));
    assign mag_w = num_w[42] ? 42'(-num_w) : 42'(num_w);
    assign lim_prod_w = 40'(rated_total_kw[21:2]) * 40'(Recip5);
    // exact for magnitudes below 2^25; anything above exceeds every limit
    assign q_prod_w = 51'(mag_reg[24:0]) * 51'(Recip125);
    assign q_w = q_prod_w[50:32];
    always_comb
    begin
        qc_w = q_w;
        if ((|mag_reg[41:25]) || (q_w > 19'(lim_reg))) qc_w = 19'(lim_reg);
        resp_w = neg_reg ? -$signed({1'b0, qc_w}) : $signed({1'b0, qc_w});
        if (mode_reg == gfrd_pkg::MODE_READY) resp_w = '0;
    end

    // ---- table ----
    logic [IdxW-1:0] ridx;
    logic [IdxW-1:0] rd_idx;
    logic idx_end;
    assign ridx = idx_reg[IdxW-1:0];
    // prefetch the next record while the walk consumes the current one
    assign rd_idx = (cmd.walk_step && !idx_end) ? IdxW'(idx_reg + 6'd1) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            loaded_reg <= '0;
        end
        else if (cmd.load && (32'(in_word.turbine_index) < WalkMax))
        begin
            running_reg[in_word.turbine_index[IdxW-1:0]] <= in_word.turbine_running;
            loaded_reg[in_word.turbine_index[IdxW-1:0]] <= 1'b1;
        end
    end

    logic [15:0] sp_w;
    always_ff @(posedge clk)
    begin
        if (cmd.load && (32'(in_word.turbine_index) < WalkMax))
        begin
            power_mem[in_word.turbine_index[IdxW-1:0]] <= in_word.turbine_power_kw;
            min_mem[in_word.turbine_index[IdxW-1:0]] <= in_word.turbine_min_kw;
            max_mem[in_word.turbine_index[IdxW-1:0]] <= in_word.turbine_max_kw;
        end
        else if (cmd.walk_step && walk_reg != 6'd0 && running_reg[ridx])
            power_mem[ridx] <= sp_w;
        pow_q <= power_mem[rd_idx];
        min_q <= min_mem[rd_idx];
        max_q <= max_mem[rd_idx];
    end
    assign pow_rd = loaded_reg[ridx] ? pow_q : '0;
    assign min_rd = min_q;
    assign max_rd = max_q;

    // setpoint
    logic signed [19:0] p_w;
    always_comb
    begin
        p_w = $signed({4'b0, pow_rd}) + 20'(per_reg);
        if (p_w > $signed({4'b0, max_rd})) p_w = $signed({4'b0, max_rd});
        if (p_w < $signed({4'b0, min_rd})) p_w = $signed({4'b0, min_rd});
        sp_w = running_reg[ridx] ? p_w[15:0] : pow_rd;
    end

    assign idx_end = (walk_reg == 6'd0) || (idx_reg + 6'd1 >= walk_reg);
    assign status.idx_end = idx_end;
    assign status.div_done = !dbusy_reg && !cmd.div_start;

    logic [18:0] rem_sh;
    assign rem_sh = {rem_reg[17:0], quo_reg[18]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= gfrd_pkg::MODE_READY;
            integ_reg <= '0;
            strobe_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            idx_reg <= '0;
            nrun_reg <= '0;
            walk_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            strobe_reg <= cmd.walk_step && (walk_reg != 6'd0);
            if (cmd.tick)
            begin
                mode_reg <= mode_next;
                if (clr_integ) integ_reg <= '0;
                dev_reg <= dev_in;
                ad_reg <= ad_in;
                walk_reg <= (turbine_count > 6'(WalkMax)) ? 6'(WalkMax) : turbine_count;
            end
            if (cmd.pi)
            begin
                if (mode_reg != gfrd_pkg::MODE_READY) integ_reg <= integ_new;
            end
            if (cmd.mag)
            begin
                mag_reg <= mag_w;
                neg_reg <= num_w[42];
                lim_reg <= lim_prod_w[39:22];
            end
            if (cmd.resp)
                resp_reg <= resp_w;
            if (cmd.count_clr)
            begin
                idx_reg <= '0;
                nrun_reg <= '0;
            end
            if (cmd.count_step)
            begin
                if (walk_reg != 6'd0 && running_reg[ridx]) nrun_reg <= nrun_reg + 6'd1;
                idx_reg <= idx_end ? 6'd0 : idx_reg + 6'd1;
            end
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg <= '0;
                rem_reg <= '0;
                dneg_reg <= resp_reg[19];
                quo_reg <= resp_reg[19] ? 19'(-resp_reg) : 19'(resp_reg);
                total_reg <= '0;
            end
            else if (dbusy_reg)
            begin
                if (nrun_reg == 6'd0)
                begin
                    dbusy_reg <= 1'b0;
                    per_reg <= '0;
                end
                else
                begin
                    if (rem_sh >= 19'(nrun_reg))
                    begin
                        rem_reg <= rem_sh - 19'(nrun_reg);
                        quo_reg <= {quo_reg[17:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[17:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd18) dbusy_reg <= 1'b0;
                end
            end
            else if (!cmd.walk_step && !cmd.count_step)
                per_reg <= dneg_reg ? -$signed({1'b0, quo_reg[17:0]})
                                    : $signed({1'b0, quo_reg[17:0]});
            if (cmd.walk_step && walk_reg != 6'd0)
            begin
                result_reg.unit_index <= idx_reg[4:0];
                result_reg.setpoint_kw <= sp_w;
                result_reg.fr_mode <= mode_reg;
                result_reg.total_power_kw <= total_reg + 21'(sp_w);
                result_reg.last <= idx_end;
                total_reg <= total_reg + 21'(sp_w);
                idx_reg <= idx_end ? 6'd0 : idx_reg + 6'd1;
            end
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;
    assign mode = mode_reg;
endmodule
`default_nettype wire
